>>> rtl/core/slcan_command_line_parser_defines.svh
// Assertion helpers used by the checker file.
`ifndef SLCAN_COMMAND_LINE_PARSER_DEFINES_SVH
`define SLCAN_COMMAND_LINE_PARSER_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define SLCAN_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, off while reset is high.
`define SLCAN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

>>> rtl/core/slcan_pkg.sv
`default_nettype none

package slcan_pkg;

   localparam int          LINE_BYTES_DEF   = 32;
   localparam logic [11:0] TORQUE_ID_RESET  = 12'h105;

   // reply codes on rsp_reply_kind
   localparam logic [1:0]  REPLY_CR         = 2'd0;
   localparam logic [1:0]  REPLY_VERSION    = 2'd1;
   localparam logic [1:0]  REPLY_FRAME      = 2'd2;

   localparam logic [7:0]  CHAR_CR          = 8'h0D;
   localparam logic [7:0]  CHAR_LF          = 8'h0A;
   localparam logic [7:0]  CHAR_OPEN        = 8'h4F;  // 'O'
   localparam logic [7:0]  CHAR_CLOSE       = 8'h43;  // 'C'
   localparam logic [7:0]  CHAR_SPEED       = 8'h53;  // 'S'
   localparam logic [7:0]  CHAR_VER_UP      = 8'h56;  // 'V'
   localparam logic [7:0]  CHAR_VER_LO      = 8'h76;  // 'v'
   localparam logic [7:0]  CHAR_FRAME       = 8'h74;  // 't'
   localparam logic [7:0]  CHAR_ZERO        = 8'h30;
   localparam logic [7:0]  CHAR_EIGHT       = 8'h38;

   // frame layout: 't', three id digits, length digit, data digits
   localparam int          FRAME_HDR_CHARS  = 5;
   localparam int          LEN_POS          = 4;
   localparam int          LAST_POS         = 8;    // second torque byte, low digit
   localparam logic [3:0]  MAX_DATA_LEN     = 4'd8;
   localparam logic [3:0]  TORQUE_MIN_LEN   = 4'd2;

   function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
      logic [7:0] d;
      begin
         if (ch >= 8'h30 && ch <= 8'h39) begin
            d = ch - 8'h30;
         end else if (ch >= 8'h41 && ch <= 8'h46) begin
            d = ch - 8'h37;
         end else if (ch >= 8'h61 && ch <= 8'h66) begin
            d = ch - 8'h57;
         end else begin
            d = 8'h00;
         end
         return d[3:0];
      end
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/slcan_command_line_parser.sv
// Channel   Ports                 Moves
// req       req_valid/req_ready   one received serial character per transfer
// rsp       rsp_valid/rsp_ready   one parsed line result per transfer
// csr       csr_valid/csr_ready   torque frame id write, always ready
//
// An ordinary character is stored as taken; the next can follow at once. A line
// end walks the line store through one RAM read port, an address and a data
// state per character: just the first for a one-letter command, nine for a
// frame; a result state then posts the result. req_ready is low throughout.
// Reset (synchronous) empties the line, closes the channel, sets the id to 0x105.
// A result waiting in the output register stalls only the next line end.
`default_nettype none

module slcan_command_line_parser #(
   parameter int LINE_BYTES = slcan_pkg::LINE_BYTES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_rx_byte,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [11:0]        csr_torque_frame_id,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_reply_kind,
   output logic                    rsp_torque_valid,
   output logic signed [15:0]      rsp_torque,
   output logic                    rsp_channel_open,
   output logic [11:0]             rsp_frame_id,
   output logic [3:0]              rsp_frame_len
);

   import slcan_pkg::*;

   localparam int            AW        = $clog2(LINE_BYTES);
   localparam logic [AW-1:0] LAST_SLOT = AW'(LINE_BYTES - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ADDR   = 4'b0010,
      ST_DATA   = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

   state_type       state_ff, state_in;
   logic [AW-1:0]   len_ff, len_in;
   logic            open_ff, open_in;
   logic [11:0]     tid_ff, tid_in;
   logic [3:0]      idx_ff, idx_in;
   logic [7:0]      first_ff, first_in;
   logic [7:0]      lch_ff, lch_in;
   logic [11:0]     fid_ff, fid_in;
   logic [15:0]     acc_ff, acc_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      kind_ff, kind_in;
   logic            tvalid_ff, tvalid_in;
   logic [15:0]     tq_ff, tq_in;
   logic            ropen_ff, ropen_in;
   logic [11:0]     rfid_ff, rfid_in;
   logic [3:0]      rlen_ff, rlen_in;

   logic            req_fire;
   logic            is_eol;
   logic            wr_en;
   logic [AW-1:0]   rd_addr;
   logic [7:0]      rd_data;
   logic [3:0]      nib;

   logic            is_frame;
   logic            lch_ok;
   logic [7:0]      lch_off;
   logic [3:0]      flen;
   logic [6:0]      len_w;
   logic [6:0]      need_w;
   logic            frame_good;
   logic            has_result;
   logic            slot_free;

   slcan_ram #(
      .WIDTH (8),
      .DEPTH (LINE_BYTES)
   ) u_line (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff),
      .wr_data (req_rx_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign is_eol    = (req_rx_byte == CHAR_CR) || (req_rx_byte == CHAR_LF);
   assign wr_en     = req_fire && !is_eol && (len_ff != LAST_SLOT);
   assign rd_addr   = AW'(idx_ff);
   assign nib       = hex_nibble(rd_data);

   // frame checks on the collected header
   assign is_frame   = (first_ff == CHAR_FRAME);
   assign lch_ok     = (lch_ff >= CHAR_ZERO) && (lch_ff <= CHAR_EIGHT);
   assign lch_off    = lch_ff - CHAR_ZERO;
   assign flen       = lch_off[3:0];
   assign len_w      = 7'(len_ff);
   assign need_w     = 7'(FRAME_HDR_CHARS) + {2'b00, flen, 1'b0};
   assign frame_good = is_frame && (len_w >= 7'(FRAME_HDR_CHARS)) && lch_ok &&
                       (len_w >= need_w);
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      open_in      = open_ff;
      tid_in       = tid_ff;
      idx_in       = idx_ff;
      first_in     = first_ff;
      lch_in       = lch_ff;
      fid_in       = fid_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      tvalid_in    = tvalid_ff;
      tq_in        = tq_ff;
      ropen_in     = ropen_ff;
      rfid_in      = rfid_ff;
      rlen_in      = rlen_ff;
      has_result   = 1'b0;

      if (csr_valid) begin
         tid_in = csr_torque_frame_id;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (is_eol) begin
                  if (len_ff != '0) begin
                     idx_in   = 4'd0;
                     state_in = ST_ADDR;
                  end
               end else if (len_ff != LAST_SLOT) begin
                  len_in = len_ff + 1'b1;
               end
            end
         end
         ST_ADDR: begin
            state_in = ST_DATA;
         end
         ST_DATA: begin
            // one character per pass through the shared hex/shift unit
            if (idx_ff == 4'd0) begin
               first_in = rd_data;
            end else if (idx_ff == 4'(LEN_POS)) begin
               fid_in = acc_ff[11:0];
               lch_in = rd_data;
            end else begin
               acc_in = {acc_ff[11:0], nib};
            end
            if ((idx_ff == 4'd0 && rd_data != CHAR_FRAME) || idx_ff == 4'(LAST_POS)) begin
               state_in = ST_RESULT;
            end else begin
               idx_in   = idx_ff + 4'd1;
               state_in = ST_ADDR;
            end
         end
         ST_RESULT: begin
            tvalid_in = 1'b0;
            tq_in     = 16'h0000;
            rfid_in   = 12'h000;
            rlen_in   = 4'd0;
            kind_in   = REPLY_CR;
            case (first_ff)
               CHAR_OPEN: begin
                  has_result = 1'b1;
                  open_in    = 1'b1;
               end
               CHAR_CLOSE: begin
                  has_result = 1'b1;
                  open_in    = 1'b0;
                  tvalid_in  = 1'b1;
               end
               CHAR_SPEED: begin
                  has_result = 1'b1;
               end
               CHAR_VER_UP, CHAR_VER_LO: begin
                  has_result = 1'b1;
                  kind_in    = REPLY_VERSION;
               end
               CHAR_FRAME: begin
                  has_result = frame_good;
                  kind_in    = REPLY_FRAME;
                  rfid_in    = fid_ff;
                  rlen_in    = flen;
                  if (fid_ff == tid_ff && flen >= TORQUE_MIN_LEN) begin
                     tvalid_in = 1'b1;
                     // little-endian: first data byte is the low byte
                     tq_in     = {acc_ff[7:0], acc_ff[15:8]};
                  end
               end
               default: begin
                  has_result = 1'b0;
               end
            endcase
            ropen_in = open_in;
            // hold until the output register can take the result
            if (!slot_free) begin
               open_in   = open_ff;
               kind_in   = kind_ff;
               tvalid_in = tvalid_ff;
               tq_in     = tq_ff;
               ropen_in  = ropen_ff;
               rfid_in   = rfid_ff;
               rlen_in   = rlen_ff;
            end else begin
               if (!has_result) begin
                  open_in   = open_ff;
                  kind_in   = kind_ff;
                  tvalid_in = tvalid_ff;
                  tq_in     = tq_ff;
                  ropen_in  = ropen_ff;
                  rfid_in   = rfid_ff;
                  rlen_in   = rlen_ff;
               end
               rsp_valid_in = has_result;
               len_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         open_ff      <= 1'b0;
         tid_ff       <= TORQUE_ID_RESET;
         idx_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         open_ff      <= open_in;
         tid_ff       <= tid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      lch_ff    <= lch_in;
      fid_ff    <= fid_in;
      acc_ff    <= acc_in;
      kind_ff   <= kind_in;
      tvalid_ff <= tvalid_in;
      tq_ff     <= tq_in;
      ropen_ff  <= ropen_in;
      rfid_ff   <= rfid_in;
      rlen_ff   <= rlen_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reply_kind   = kind_ff;
   assign rsp_torque_valid = tvalid_ff;
   assign rsp_torque       = signed'(tq_ff);
   assign rsp_channel_open = ropen_ff;
   assign rsp_frame_id     = rfid_ff;
   assign rsp_frame_len    = rlen_ff;

endmodule

`default_nettype wire

>>> rtl/core/slcan_ram.sv
`default_nettype none

module slcan_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/core/slcan_checker.sv
`default_nettype none
`include "slcan_command_line_parser_defines.svh"

module slcan_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [1:0]         rsp_reply_kind,
   input wire logic               rsp_torque_valid,
   input wire logic signed [15:0] rsp_torque,
   input wire logic               rsp_channel_open,
   input wire logic [11:0]        rsp_frame_id,
   input wire logic [3:0]         rsp_frame_len
);

   import slcan_pkg::*;

   // a stalled result keeps its payload
   `SLCAN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_torque) && $stable(rsp_reply_kind))

   // only a frame reply carries id and length, and the length fits a frame
   `SLCAN_ASSERT_NOW(a_frame_fields, clock, reset, rsp_valid && rsp_reply_kind != REPLY_FRAME, rsp_frame_id == 12'h000 && rsp_frame_len == 4'd0)

   `SLCAN_ASSERT_NOW(a_kind_len, clock, reset, rsp_valid, (rsp_reply_kind == REPLY_CR || rsp_reply_kind == REPLY_VERSION || rsp_reply_kind == REPLY_FRAME) && rsp_frame_len <= MAX_DATA_LEN)

   // a torque command on a plain ack is the close command: zero, channel closed
   `SLCAN_ASSERT_NOW(a_close_torque, clock, reset, rsp_valid && rsp_torque_valid && rsp_reply_kind == REPLY_CR, rsp_torque == 16'sd0 && !rsp_channel_open)

   // a torque frame carries at least two data bytes; the version reply none
   `SLCAN_ASSERT_NOW(a_torque_src, clock, reset, rsp_valid && rsp_torque_valid, rsp_reply_kind != REPLY_VERSION && (rsp_reply_kind == REPLY_CR || rsp_frame_len >= TORQUE_MIN_LEN))

endmodule

bind slcan_command_line_parser slcan_checker u_checker (.*);

`default_nettype wire
